### rtl/rotated_rect_fill_framebuffer_defines.svh
// assertion macros shared by the rectangle fill frame store modules
`ifndef ROTATED_RECT_FILL_FRAMEBUFFER_DEFINES_SVH
`define ROTATED_RECT_FILL_FRAMEBUFFER_DEFINES_SVH

// antecedent holds in a cycle, consequent must hold in the same cycle
`define RRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// expression must hold at every edge out of reset
`define RRF_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

### rtl/rrf_pkg.sv
// types, constants and address mapping for the rectangle fill frame store
package rrf_pkg;

    localparam int BUF_W       = 128;
    localparam int BUF_H       = 128;
    localparam int STORE_WORDS = BUF_W * BUF_H;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int COORD_W     = 7;
    localparam int COLOR_W     = 16;
    localparam int RIDX_W      = 14;
    localparam int COORD_SPAN  = 1 << COORD_W;

    // signed width that holds any mapped address for any mode
    localparam int MAP_W = $clog2((BUF_H + COORD_SPAN) * BUF_W + COORD_SPAN) + 2;

    // width that holds a read index, the store size and the store address
    localparam int IDX_W = ((ADDR_W > RIDX_W) ? ADDR_W : RIDX_W) + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_ROTATION_MODE = '0;

    typedef enum logic [2:0] {
        ROT_NONE      = 3'd0,
        ROT_MIRROR_X  = 3'd1,
        ROT_90        = 3'd2,
        ROT_90_MIRROR = 3'd3,
        ROT_180       = 3'd4,
        ROT_MIRROR_Y  = 3'd5,
        ROT_270       = 3'd6,
        ROT_TRANSPOSE = 3'd7
    } t_rotation;

    typedef enum logic [1:0] {
        KIND_FILL,
        KIND_EMPTY,
        KIND_READ
    } t_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FILL,
        BK_FINISH
    } t_back_state;

    typedef struct packed {
        t_kind               kind;
        logic [COORD_W-1:0]  x_start;
        logic [COORD_W-1:0]  y_start;
        logic [COORD_W-1:0]  x_end;
        logic [COORD_W-1:0]  y_end;
        logic [COLOR_W-1:0]  color;
        logic                rd_ok;
        logic [ADDR_W-1:0]   rd_addr;
    } t_cmd;

    function automatic logic signed [MAP_W-1:0] map_address(
        t_rotation mode, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        logic signed [MAP_W-1:0] sx;
        logic signed [MAP_W-1:0] sy;
        logic signed [MAP_W-1:0] w;
        logic signed [MAP_W-1:0] h;
        logic signed [MAP_W-1:0] one;
        logic signed [MAP_W-1:0] row;
        logic signed [MAP_W-1:0] col;
        sx  = signed'(MAP_W'(x));
        sy  = signed'(MAP_W'(y));
        w   = MAP_W'(BUF_W);
        h   = MAP_W'(BUF_H);
        one = MAP_W'(1);
        unique case (mode)
            ROT_NONE:      begin row = sy;            col = sx;        end
            ROT_MIRROR_X:  begin row = sy + one;      col = -sx - one; end
            ROT_90:        begin row = sx + one;      col = -sy - one; end
            ROT_90_MIRROR: begin row = h - sx;        col = -sy - one; end
            ROT_180:       begin row = h - sy;        col = -sx - one; end
            ROT_MIRROR_Y:  begin row = h - sy - one;  col = sx;        end
            ROT_270:       begin row = h - one - sx;  col = sy;        end
            ROT_TRANSPOSE: begin row = sx;            col = sy;        end
            default:       begin row = sy;            col = sx;        end
        endcase
        return row * w + col;
    endfunction

    function automatic logic in_store(logic signed [MAP_W-1:0] a);
        return (a >= 0) && (a < signed'(MAP_W'(STORE_WORDS)));
    endfunction

endpackage

### rtl/rotated_rect_fill_framebuffer.sv
// top level of the rotated rectangle fill frame store
//
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+------------------------------------
// command   | in        | i_in_valid / o_in_stall    | command, corners, color, read index
// result    | out       | o_out_valid / i_out_stall  | read_color, clipped, done_res
// config    | in        | psel, penable, pwrite      | rotation_mode at byte address 0
//
// a fill walks one covered pixel per cycle, set by the single store write port
// a read or an empty fill goes from idle straight to the finish state in the back engine
// a two entry queue lets commands transfer in while the engine works
// a finished result waits in the output register, the engine holds its next result until free
// synchronous active-low reset clears the control state, the store keeps its contents
module rotated_rect_fill_framebuffer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic [rrf_pkg::COORD_W-1:0]       i_x_start,
    input  logic [rrf_pkg::COORD_W-1:0]       i_y_start,
    input  logic [rrf_pkg::COORD_W-1:0]       i_x_end,
    input  logic [rrf_pkg::COORD_W-1:0]       i_y_end,
    input  logic [rrf_pkg::COLOR_W-1:0]       i_fill_color,
    input  logic [rrf_pkg::RIDX_W-1:0]        i_read_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rrf_pkg::COLOR_W-1:0]       o_read_color,
    output logic                              o_clipped,
    output logic                              o_done_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rrf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rrf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rrf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    rrf_pkg::t_rotation   r_rotation_mode;
    logic                 cfg_write;
    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_empty;
    rrf_pkg::t_cmd        q_in_cmd;
    rrf_pkg::t_cmd        q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation_mode <= rrf_pkg::ROT_NONE;
        end else if (cfg_write &&
                     (paddr[rrf_pkg::APB_ADDR_W-1:2] == rrf_pkg::REG_ROTATION_MODE)) begin
            r_rotation_mode <= rrf_pkg::t_rotation'(pwdata[2:0]);
        end
    end

    always_comb begin
        if (paddr[rrf_pkg::APB_ADDR_W-1:2] == rrf_pkg::REG_ROTATION_MODE) begin
            prdata = rrf_pkg::APB_DATA_W'(r_rotation_mode);
        end else begin
            prdata = '0;
        end
    end

    rrf_front u_front (
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_command    (i_command),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_fill_color (i_fill_color),
        .i_read_index (i_read_index),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_cmd        (q_in_cmd)
    );

    rrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    rrf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rotation_mode (r_rotation_mode),
        .i_head          (q_head),
        .i_empty         (q_empty),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_read_color    (o_read_color),
        .o_clipped       (o_clipped)
    );

    assign o_done_res = 1'b1;

endmodule

### rtl/rrf_ram.sv
// generic single write, single read ram with registered read data
module rrf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rrf_queue.sv
// short command queue between the front and the back engine
`include "rotated_rect_fill_framebuffer_defines.svh"

module rrf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rrf_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output rrf_pkg::t_cmd o_head,
    output logic          o_empty
);

    rrf_pkg::t_cmd               r_mem [rrf_pkg::QUEUE_DEPTH];
    logic [rrf_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [rrf_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [rrf_pkg::QCNT_W-1:0]  r_count;
    logic [rrf_pkg::QPTR_W-1:0]  n_wr_ptr;
    logic [rrf_pkg::QPTR_W-1:0]  n_rd_ptr;

    localparam logic [rrf_pkg::QPTR_W-1:0] LAST_PTR = rrf_pkg::QPTR_W'(rrf_pkg::QUEUE_DEPTH - 1);

    always_comb begin
        n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == rrf_pkg::QCNT_W'(rrf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    `RRF_ASSERT_IMPLY(a_no_push_when_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `RRF_ASSERT_IMPLY(a_no_pop_when_empty, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")

endmodule

### rtl/rrf_front.sv
// input side: takes commands, sorts them into fill, empty fill or read
module rrf_front (
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [rrf_pkg::COORD_W-1:0]   i_x_start,
    input  logic [rrf_pkg::COORD_W-1:0]   i_y_start,
    input  logic [rrf_pkg::COORD_W-1:0]   i_x_end,
    input  logic [rrf_pkg::COORD_W-1:0]   i_y_end,
    input  logic [rrf_pkg::COLOR_W-1:0]   i_fill_color,
    input  logic [rrf_pkg::RIDX_W-1:0]    i_read_index,
    input  logic                          i_full,
    output logic                          o_push,
    output rrf_pkg::t_cmd                 o_cmd
);

    logic [rrf_pkg::IDX_W-1:0] idx_ext;

    always_comb begin
        idx_ext = rrf_pkg::IDX_W'(i_read_index);

        o_cmd.x_start = i_x_start;
        o_cmd.y_start = i_y_start;
        o_cmd.x_end   = i_x_end;
        o_cmd.y_end   = i_y_end;
        o_cmd.color   = i_fill_color;
        o_cmd.rd_ok   = (idx_ext < rrf_pkg::IDX_W'(rrf_pkg::STORE_WORDS));
        o_cmd.rd_addr = idx_ext[rrf_pkg::ADDR_W-1:0];

        // a rectangle with start past end covers no pixel
        priority if (i_command) begin
            o_cmd.kind = rrf_pkg::KIND_READ;
        end else if ((i_x_start > i_x_end) || (i_y_start > i_y_end)) begin
            o_cmd.kind = rrf_pkg::KIND_EMPTY;
        end else begin
            o_cmd.kind = rrf_pkg::KIND_FILL;
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

### rtl/rrf_back.sv
// back engine: walks fill rectangles one pixel a cycle, serves reads, holds the result
`include "rotated_rect_fill_framebuffer_defines.svh"

module rrf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrf_pkg::t_rotation            i_rotation_mode,
    input  rrf_pkg::t_cmd                 i_head,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rrf_pkg::COLOR_W-1:0]   o_read_color,
    output logic                          o_clipped
);

    rrf_pkg::t_back_state               r_state;
    rrf_pkg::t_back_state               n_state;
    logic [rrf_pkg::COORD_W-1:0]        r_x;
    logic [rrf_pkg::COORD_W-1:0]        r_y;
    logic [rrf_pkg::COORD_W-1:0]        r_x_start;
    logic [rrf_pkg::COORD_W-1:0]        r_x_end;
    logic [rrf_pkg::COORD_W-1:0]        r_y_end;
    logic [rrf_pkg::COLOR_W-1:0]        r_color;
    logic                               r_clip;
    logic                               r_is_read;
    logic                               r_rd_ok;
    logic                               r_out_valid;
    logic [rrf_pkg::COLOR_W-1:0]        r_out_color;
    logic                               r_out_clipped;

    logic signed [rrf_pkg::MAP_W-1:0]   pix_addr;
    logic                               pix_in;
    logic                               last_pix;
    logic                               can_load;
    logic                               load_result;
    logic                               ram_we;
    logic                               ram_rd_en;
    logic [rrf_pkg::COLOR_W-1:0]        ram_rdata;

    always_comb begin
        pix_addr = rrf_pkg::map_address(i_rotation_mode, r_x, r_y);
        pix_in   = rrf_pkg::in_store(pix_addr);
        last_pix = (r_x == r_x_end) && (r_y == r_y_end);
        // result slot is free, or is taken in this cycle
        can_load = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        load_result = 1'b0;
        unique case (r_state)
            rrf_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_head.kind == rrf_pkg::KIND_FILL) begin
                        n_state = rrf_pkg::BK_FILL;
                    end else begin
                        n_state = rrf_pkg::BK_FINISH;
                    end
                end
            end
            rrf_pkg::BK_FILL: begin
                if (last_pix) begin
                    n_state = rrf_pkg::BK_FINISH;
                end
            end
            rrf_pkg::BK_FINISH: begin
                if (can_load) begin
                    load_result = 1'b1;
                    n_state     = rrf_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = rrf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrf_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x       <= i_head.x_start;
            r_y       <= i_head.y_start;
            r_x_start <= i_head.x_start;
            r_x_end   <= i_head.x_end;
            r_y_end   <= i_head.y_end;
            r_color   <= i_head.color;
            r_clip    <= 1'b0;
            r_is_read <= (i_head.kind == rrf_pkg::KIND_READ);
            r_rd_ok   <= i_head.rd_ok;
        end else if (r_state == rrf_pkg::BK_FILL) begin
            r_clip <= r_clip || !pix_in;
            if (r_x == r_x_end) begin
                r_x <= r_x_start;
                r_y <= r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_result) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_result) begin
            r_out_color   <= (r_is_read && r_rd_ok) ? ram_rdata : '0;
            r_out_clipped <= !r_is_read && r_clip;
        end
    end

    assign ram_we    = (r_state == rrf_pkg::BK_FILL) && pix_in;
    assign ram_rd_en = o_pop && (i_head.kind == rrf_pkg::KIND_READ);

    rrf_ram #(
        .WIDTH (rrf_pkg::COLOR_W),
        .DEPTH (rrf_pkg::STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (pix_addr[rrf_pkg::ADDR_W-1:0]),
        .i_wdata (r_color),
        .i_rd_en (ram_rd_en),
        .i_raddr (i_head.rd_addr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_read_color = r_out_color;
    assign o_clipped    = r_out_clipped;

    `RRF_ASSERT_IMPLY(a_fill_in_rect, i_clk, i_rst_n, r_state == rrf_pkg::BK_FILL, (r_x >= r_x_start) && (r_x <= r_x_end) && (r_y <= r_y_end), "fill walker left the rectangle")
    `RRF_ASSERT_IMPLY(a_result_kind, i_clk, i_rst_n, o_out_valid, !(o_clipped && (o_read_color != '0)), "result mixes read data and clip flag")

endmodule
